// ===== src/pcmp_pkg.sv =====
// Shared constants and types for the partition count block.
package pcmp_pkg;

	localparam int MAX_N       = 1023;
	localparam int ROW_DEPTH   = MAX_N + 1;
	localparam int IDX_W       = $clog2(ROW_DEPTH);
	localparam int FIELD_W     = 10;
	localparam int COUNT_W     = 30;
	localparam int IN_TDATA_W  = ((2 * FIELD_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((COUNT_W + 7) / 8) * 8;

	localparam logic [COUNT_W:0] PRIME_MOD = 31'd1000000007;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_CLEAR  = 5'b00010,
		ST_UPDATE = 5'b00100,
		ST_READ   = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

endpackage

// ===== src/partition_count_mod_prime_core.sv =====
// Top level: counts partitions of n into at most k parts, modulo 1000000007.
//
// Channel  Dir  tdata fields (low bit first)          Handshake
// s_axis   in   total[9:0], parts[19:10], pad to 24   s_tvalid / s_tready
// m_axis   out  count[29:0], pad to 32                m_tvalid / m_tready
//
// Each word is accepted, clears row entries 0..n, updates entries j..n for each
// j = 1..min(k,n), then reads f[n] in the read and done states.
// The single write port of the row RAM sets the pace: one update per cycle.
// Reset clears only the sequencer, its counters and valid flags; the row RAM is cleared
// by every word before use, so there is no clearing pass after reset.
// s_tready is high only in idle; a finished count waits in the output
// register and the next word may be taken while it waits.
module partition_count_mod_prime_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [pcmp_pkg::IN_TDATA_W-1:0]    s_tdata,   // total[9:0], parts[19:10]
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [pcmp_pkg::OUT_TDATA_W-1:0]   m_tdata    // count[29:0]
);
	import pcmp_pkg::*;

	// Sequencer and counters.
	state_t              state_q;
	logic [IDX_W-1:0]    n_q;
	logic [IDX_W-1:0]    k_q;
	logic [IDX_W-1:0]    j_q;        // part counter
	logic [IDX_W-1:0]    i_q;        // sum counter / clear address
	logic                zero_q;     // request too large for the row

	// Update pipeline: issue in stage 0, add and write in stage 1.
	logic                upd_vld_s1;
	logic [IDX_W-1:0]    upd_addr_s1;
	logic                fwd_a_s1;
	logic                fwd_b_s1;
	logic [COUNT_W-1:0]  fwd_data_q;

	// Output register.
	logic                out_vld_q;
	logic [COUNT_W-1:0]  out_data_q;

	// Input fields.
	logic [FIELD_W-1:0]  in_total;
	logic [FIELD_W-1:0]  in_parts;
	logic [FIELD_W-1:0]  parts_clamped;

	// RAM ports and the modular adder.
	logic [IDX_W-1:0]    rd_addr_a;
	logic [IDX_W-1:0]    rd_addr_b;
	logic [COUNT_W-1:0]  rd_data_a;
	logic [COUNT_W-1:0]  rd_data_b;
	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr;
	logic [COUNT_W-1:0]  ram_wdata;
	logic [COUNT_W-1:0]  op_a;
	logic [COUNT_W-1:0]  op_b;
	logic [COUNT_W:0]    sum_raw;
	logic [COUNT_W-1:0]  sum_mod;
	logic [COUNT_W-1:0]  result;
	logic                in_acc;
	logic                out_free;

	assign in_total      = s_tdata[FIELD_W-1:0];
	assign in_parts      = s_tdata[2*FIELD_W-1:FIELD_W];
	assign parts_clamped = (in_parts > in_total) ? in_total : in_parts;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !out_vld_q || m_tready;

	assign m_tvalid = out_vld_q;
	assign m_tdata  = OUT_TDATA_W'(out_data_q);

	// Read f[i] and f[i-j] while updating; hold the read on f[n] at the end.
	assign rd_addr_a = (state_q == ST_READ || state_q == ST_DONE) ? n_q : i_q;
	assign rd_addr_b = i_q - j_q;

	// Forward the word written in the same cycle the RAM was read.
	assign op_a = fwd_a_s1 ? fwd_data_q : rd_data_a;
	assign op_b = fwd_b_s1 ? fwd_data_q : rd_data_b;

	// Modular add with one conditional subtract.
	assign sum_raw = {1'b0, op_a} + {1'b0, op_b};
	assign sum_mod = (sum_raw >= PRIME_MOD) ? COUNT_W'(sum_raw - PRIME_MOD)
	                                        : COUNT_W'(sum_raw);

	// Clear writes 1 at entry 0 and 0 elsewhere; the update stage writes the sum.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = upd_addr_s1;
		ram_wdata = sum_mod;
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = i_q;
			ram_wdata = (i_q == '0) ? COUNT_W'(1) : '0;
		end else if (upd_vld_s1) begin
			ram_we = 1'b1;
		end
	end

	assign result = zero_q ? '0 : op_a;

	pcmp_ram #(
		.WIDTH (COUNT_W),
		.DEPTH (ROW_DEPTH)
	) u_row (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (rd_addr_a),
		.rdata_a (rd_data_a),
		.raddr_b (rd_addr_b),
		.rdata_b (rd_data_b)
	);

	// Sequencer: control state with reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			j_q        <= '0;
			i_q        <= '0;
			upd_vld_s1 <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			upd_vld_s1 <= (state_q == ST_UPDATE);
			// Load the output flag when a count is handed over, drop it once taken.
			if (state_q == ST_DONE && out_free) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && m_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						i_q <= '0;
						if (32'(in_total) > 32'(MAX_N)) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_CLEAR;
						end
					end
				end
				ST_CLEAR: begin
					if (i_q == n_q) begin
						// Skip the update pass when there are no parts to add.
						if (k_q == '0) begin
							state_q <= ST_READ;
						end else begin
							state_q <= ST_UPDATE;
							j_q     <= IDX_W'(1);
							i_q     <= IDX_W'(1);
						end
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				ST_UPDATE: begin
					if (i_q == n_q) begin
						if (j_q == k_q) begin
							state_q <= ST_READ;
						end else begin
							j_q <= j_q + 1'b1;
							i_q <= j_q + 1'b1;
						end
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				ST_READ: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// Hold the count until the output register is free.
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers, no reset.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			n_q    <= IDX_W'(in_total);
			k_q    <= IDX_W'(parts_clamped);
			zero_q <= (32'(in_total) > 32'(MAX_N));
		end
		upd_addr_s1 <= i_q;
		fwd_a_s1    <= upd_vld_s1 && (upd_addr_s1 == rd_addr_a);
		fwd_b_s1    <= upd_vld_s1 && (upd_addr_s1 == rd_addr_b);
		if (upd_vld_s1) begin
			fwd_data_q <= sum_mod;
		end
		if (state_q == ST_DONE && out_free) begin
			out_data_q <= result;
		end
	end

`ifndef SYNTHESIS
	// A count on the output is always reduced below the prime.
	a_count_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> ({1'b0, out_data_q} < PRIME_MOD))
		else $error("count not reduced");

	// The update stage only follows an issue cycle.
	a_upd_follows_issue: assert property (@(posedge clk) disable iff (!arst_n)
		upd_vld_s1 |-> $past(state_q == ST_UPDATE))
		else $error("update write without issue");

	// Counters stay inside the triangle j <= i, j <= k during updates.
	a_counter_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE) |-> (j_q <= i_q && j_q <= k_q && j_q != '0))
		else $error("update counters out of range");

	// A finished count reaches the output register when it is free.
	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> (out_vld_q && state_q == ST_IDLE))
		else $error("count not delivered");
`endif

endmodule

// ===== src/pcmp_ram.sv =====
// Generic RAM: one write port, two read ports, registered read data.
module pcmp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule
